FILE: hdl/upv_pkg.sv
package upv_pkg;

   typedef enum logic [1:0] {
      CASE_CROSS = 2'd0,
      CASE_PERP  = 2'd1,
      CASE_AXIS  = 2'd2
   } case_code_type;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam logic REG_CROSS_LIMIT  = 1'b0;
   localparam logic REG_LENGTH_LIMIT = 1'b1;
   localparam int CROSS_LIMIT_WIDTH  = 63;
   localparam int LENGTH_LIMIT_WIDTH = 32;

endpackage

FILE: hdl/unit_perpendicular_vector.sv
// pipeline stages from accepted request word to response word:
// 5 front stages, 1 queue slot, 1 square, 2*OUT_FRAC_BITS+1 divide, OUT_FRAC_BITS+1 root, 1 out
// throughput: one word per cycle while no pipeline is stalled by back-pressure, every stage is pipelined
// a 2-entry queue separates the front and back pipelines, each stalls on its own
// reset: synchronous active high, clears pipeline valids, queue and both limit registers
module unit_perpendicular_vector #(
   parameter int IN_WIDTH      = 16,
   parameter int OUT_FRAC_BITS = 22
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z
   input  logic [((6*IN_WIDTH+7)/8)*8-1:0]           req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // unit_x, unit_y, unit_z
   output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]  rsp_tdata,
   // case_code
   output logic [1:0]                                rsp_tuser,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [upv_pkg::CSR_ADDR_WIDTH-1:0]        csr_paddr,
   input  logic [upv_pkg::CSR_DATA_WIDTH-1:0]        csr_pwdata,
   output logic [upv_pkg::CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                                      csr_pready
);
   import upv_pkg::*;

   localparam int IW  = IN_WIDTH;
   localparam int MW  = 2 * IW + 1;
   localparam int SW  = 4 * IW + 4;
   localparam int OW  = OUT_FRAC_BITS + 2;
   localparam int RDW = ((3 * OW + 7) / 8) * 8;
   localparam int QDW = 3 * MW + SW + 2;

   logic [CROSS_LIMIT_WIDTH-1:0]  cross_limit_ff;
   logic [LENGTH_LIMIT_WIDTH-1:0] length_limit_ff;
   logic                          wr_en;
   logic                          reg_sel;

   logic                 f_valid, f_ready, b_valid, b_ready;
   logic signed [MW-1:0] f_wx, f_wy, f_wz, b_wx, b_wy, b_wz;
   logic [SW-1:0]        f_s, b_s;
   case_code_type        f_code, b_code, o_code;
   logic [QDW-1:0]       q_in_data, q_out_data;
   logic signed [OW-1:0] o_x, o_y, o_z;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_limit_ff  <= '0;
         length_limit_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_CROSS_LIMIT:  cross_limit_ff  <= csr_pwdata[CROSS_LIMIT_WIDTH-1:0];
            REG_LENGTH_LIMIT: length_limit_ff <= csr_pwdata[LENGTH_LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CROSS_LIMIT:  csr_prdata = CSR_DATA_WIDTH'(cross_limit_ff);
         REG_LENGTH_LIMIT: csr_prdata = CSR_DATA_WIDTH'(length_limit_ff);
         default:          csr_prdata = '0;
      endcase
   end

   upv_front #(
      .IN_WIDTH (IN_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .a_x          (req_tdata[0*IW +: IW]),
      .a_y          (req_tdata[1*IW +: IW]),
      .a_z          (req_tdata[2*IW +: IW]),
      .b_x          (req_tdata[3*IW +: IW]),
      .b_y          (req_tdata[4*IW +: IW]),
      .b_z          (req_tdata[5*IW +: IW]),
      .cross_limit  (cross_limit_ff),
      .length_limit (length_limit_ff),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .w_x          (f_wx),
      .w_y          (f_wy),
      .w_z          (f_wz),
      .s            (f_s),
      .code         (f_code)
   );

   assign q_in_data = {f_code, f_s, f_wz, f_wy, f_wx};

   upv_fifo #(
      .WIDTH (QDW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out_data)
   );

   assign b_wx   = q_out_data[0*MW +: MW];
   assign b_wy   = q_out_data[1*MW +: MW];
   assign b_wz   = q_out_data[2*MW +: MW];
   assign b_s    = q_out_data[3*MW +: SW];
   assign b_code = case_code_type'(q_out_data[QDW-1 -: 2]);

   upv_back #(
      .IN_WIDTH      (IN_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .w_x       (b_wx),
      .w_y       (b_wy),
      .w_z       (b_wz),
      .s         (b_s),
      .code      (b_code),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .unit_x    (o_x),
      .unit_y    (o_y),
      .unit_z    (o_z),
      .case_code (o_code)
   );

   assign rsp_tdata = RDW'({o_z, o_y, o_x});
   assign rsp_tuser = o_code;

endmodule

FILE: hdl/upv_front.sv
module upv_front #(
   parameter int IN_WIDTH = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic signed [IN_WIDTH-1:0]                  a_x,
   input  logic signed [IN_WIDTH-1:0]                  a_y,
   input  logic signed [IN_WIDTH-1:0]                  a_z,
   input  logic signed [IN_WIDTH-1:0]                  b_x,
   input  logic signed [IN_WIDTH-1:0]                  b_y,
   input  logic signed [IN_WIDTH-1:0]                  b_z,
   input  logic [upv_pkg::CROSS_LIMIT_WIDTH-1:0]       cross_limit,
   input  logic [upv_pkg::LENGTH_LIMIT_WIDTH-1:0]      length_limit,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic signed [2*IN_WIDTH:0]                  w_x,
   output logic signed [2*IN_WIDTH:0]                  w_y,
   output logic signed [2*IN_WIDTH:0]                  w_z,
   output logic [4*IN_WIDTH+3:0]                       s,
   output upv_pkg::case_code_type                      code
);
   import upv_pkg::*;

   localparam int IW  = IN_WIDTH;
   localparam int PW  = 2 * IW;
   localparam int MW  = 2 * IW + 1;
   localparam int SW  = 4 * IW + 4;
   localparam int LW  = 2 * IW + 2;
   localparam int LCW = (LW > LENGTH_LIMIT_WIDTH) ? LW : LENGTH_LIMIT_WIDTH;
   localparam int XCW = (SW > CROSS_LIMIT_WIDTH) ? SW : CROSS_LIMIT_WIDTH;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   logic signed [PW-1:0] p1_ff [6];
   logic [PW-1:0]        aa1_ff [3];
   logic [PW-1:0]        bb1_ff [3];
   logic signed [IW-1:0] a1_ff [3];
   logic signed [IW-1:0] b1_ff [3];

   logic signed [MW-1:0] c2_ff [3];
   logic [LW-1:0]        la2_ff, lb2_ff;
   logic [PW-1:0]        aa2_ff [3];
   logic [PW-1:0]        bb2_ff [3];
   logic signed [IW-1:0] a2_ff [3];
   logic signed [IW-1:0] b2_ff [3];

   logic [MW-1:0]        cm_in [3];
   logic signed [MW-1:0] c3_ff [3];
   logic [SW-1:0]        csq3_ff [3];
   logic signed [IW-1:0] d3_ff [3];
   logic [PW-1:0]        dd3_ff [3];
   logic [LW-1:0]        ld3_ff;

   logic [IW:0]          ad_in [3];
   logic [1:0]           p_in, q_in;
   logic signed [MW-1:0] wd_in [3];
   logic signed [MW-1:0] c4_ff [3];
   logic signed [MW-1:0] wd4_ff [3];
   logic [SW-1:0]        sc4_ff, sd4_ff;
   logic                 small4_ff;

   logic                 cross_ok;
   logic signed [MW-1:0] w5_ff [3];
   logic [SW-1:0]        s5_ff;
   case_code_type        code5_ff;

   assign en       = !v5_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // products and input squares
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff[0]  <= a_y * b_z;
         p1_ff[1]  <= a_z * b_y;
         p1_ff[2]  <= a_z * b_x;
         p1_ff[3]  <= a_x * b_z;
         p1_ff[4]  <= a_x * b_y;
         p1_ff[5]  <= a_y * b_x;
         aa1_ff[0] <= PW'(a_x * a_x);
         aa1_ff[1] <= PW'(a_y * a_y);
         aa1_ff[2] <= PW'(a_z * a_z);
         bb1_ff[0] <= PW'(b_x * b_x);
         bb1_ff[1] <= PW'(b_y * b_y);
         bb1_ff[2] <= PW'(b_z * b_z);
         a1_ff[0]  <= a_x;
         a1_ff[1]  <= a_y;
         a1_ff[2]  <= a_z;
         b1_ff[0]  <= b_x;
         b1_ff[1]  <= b_y;
         b1_ff[2]  <= b_z;
      end
   end

   // cross product and input lengths
   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff[0] <= MW'(p1_ff[0]) - MW'(p1_ff[1]);
         c2_ff[1] <= MW'(p1_ff[2]) - MW'(p1_ff[3]);
         c2_ff[2] <= MW'(p1_ff[4]) - MW'(p1_ff[5]);
         la2_ff   <= LW'(aa1_ff[0]) + LW'(aa1_ff[1]) + LW'(aa1_ff[2]);
         lb2_ff   <= LW'(bb1_ff[0]) + LW'(bb1_ff[1]) + LW'(bb1_ff[2]);
         aa2_ff   <= aa1_ff;
         bb2_ff   <= bb1_ff;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cm_in[i] = c2_ff[i][MW-1] ? MW'(-c2_ff[i]) : MW'(c2_ff[i]);
      end
   end

   // cross squares and choice of larger input
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            csq3_ff[i] <= SW'(cm_in[i] * cm_in[i]);
         end
         c3_ff <= c2_ff;
         if (la2_ff < lb2_ff) begin
            d3_ff  <= b2_ff;
            dd3_ff <= bb2_ff;
            ld3_ff <= lb2_ff;
         end else begin
            d3_ff  <= a2_ff;
            dd3_ff <= aa2_ff;
            ld3_ff <= la2_ff;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ad_in[i] = d3_ff[i][IW-1] ? (IW+1)'(-d3_ff[i]) : (IW+1)'(d3_ff[i]);
         wd_in[i] = '0;
      end
      if (ad_in[0] < ad_in[1]) begin
         p_in = 2'd1;
         q_in = (ad_in[0] < ad_in[2]) ? 2'd2 : 2'd0;
      end else begin
         p_in = 2'd0;
         q_in = (ad_in[1] < ad_in[2]) ? 2'd2 : 2'd1;
      end
      wd_in[p_in] = MW'(d3_ff[q_in]);
      wd_in[q_in] = -MW'(d3_ff[p_in]);
   end

   // cross magnitude and perpendicular candidate
   always_ff @(posedge clock) begin
      if (en) begin
         sc4_ff    <= csq3_ff[0] + csq3_ff[1] + csq3_ff[2];
         sd4_ff    <= SW'(dd3_ff[p_in]) + SW'(dd3_ff[q_in]);
         small4_ff <= LCW'(ld3_ff) <= LCW'(length_limit);
         wd4_ff    <= wd_in;
         c4_ff     <= c3_ff;
      end
   end

   assign cross_ok = XCW'(sc4_ff) > XCW'(cross_limit);

   always_ff @(posedge clock) begin
      if (en) begin
         if (cross_ok) begin
            w5_ff    <= c4_ff;
            s5_ff    <= sc4_ff;
            code5_ff <= CASE_CROSS;
         end else if (small4_ff) begin
            w5_ff[0] <= MW'(1);
            w5_ff[1] <= '0;
            w5_ff[2] <= '0;
            s5_ff    <= SW'(1);
            code5_ff <= CASE_AXIS;
         end else begin
            w5_ff    <= wd4_ff;
            s5_ff    <= sd4_ff;
            code5_ff <= CASE_PERP;
         end
      end
   end

   assign out_valid = v5_ff;
   assign w_x       = w5_ff[0];
   assign w_y       = w5_ff[1];
   assign w_z       = w5_ff[2];
   assign s         = s5_ff;
   assign code      = code5_ff;

endmodule

FILE: hdl/upv_fifo.sv
module upv_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       count_ff;
   logic             push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

FILE: hdl/upv_lane.sv
module upv_lane #(
   parameter int IN_WIDTH      = 16,
   parameter int OUT_FRAC_BITS = 22
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [2*IN_WIDTH:0]      m,
   input  logic [4*IN_WIDTH+3:0]    s,
   output logic [OUT_FRAC_BITS:0]   root
);

   localparam int SW = 4 * IN_WIDTH + 4;
   localparam int F  = OUT_FRAC_BITS;
   localparam int QW = 2 * F + 1;
   localparam int XW = 2 * F + 2;

   logic [SW-1:0]  sq_ff, s0_ff;
   logic [SW-1:0]  r_ff [QW];
   logic [SW-1:0]  sd_ff [QW];
   logic [QW-1:0]  q_ff [QW];
   logic [F+2:0]   rem_ff [F+1];
   logic [F:0]     rt_ff [F+1];
   logic [XW-1:0]  x_ff [F+1];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= SW'(m * m);
         s0_ff <= s;
      end
   end

   // restoring division of m^2 * 2^(2F) by s, one quotient bit a stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [SW-1:0] r_prev, s_prev;
      logic [QW-1:0] q_prev;
      logic          b;
      logic [SW:0]   t;
      logic          ge;
      if (k == 0) begin : g_first
         assign r_prev = sq_ff >> 1;
         assign s_prev = s0_ff;
         assign q_prev = '0;
         assign b      = sq_ff[0];
      end else begin : g_next
         assign r_prev = r_ff[k-1];
         assign s_prev = sd_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign b      = 1'b0;
      end
      assign t  = {r_prev, b};
      assign ge = t >= {1'b0, s_prev};
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]  <= ge ? SW'(t - {1'b0, s_prev}) : t[SW-1:0];
            sd_ff[k] <= s_prev;
            q_ff[k]  <= {q_prev[QW-2:0], ge};
         end
      end
   end

   // digit-by-digit square root, one root bit a stage
   for (genvar j = 0; j <= F; j++) begin : g_sqrt
      logic [F+2:0]  rem_prev;
      logic [F:0]    rt_prev;
      logic [XW-1:0] x_prev;
      logic [F+4:0]  cand, trial;
      logic          ge;
      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign rt_prev  = '0;
         assign x_prev   = {1'b0, q_ff[QW-1]};
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign rt_prev  = rt_ff[j-1];
         assign x_prev   = x_ff[j-1];
      end
      assign cand  = {rem_prev, x_prev[2*(F-j)+1 -: 2]};
      assign trial = {2'b00, rt_prev, 2'b01};
      assign ge    = cand >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? (F+3)'(cand - trial) : cand[F+2:0];
            rt_ff[j]  <= {rt_prev[F-1:0], ge};
            x_ff[j]   <= x_prev;
         end
      end
   end

   assign root = rt_ff[F];

endmodule

FILE: hdl/upv_back.sv
module upv_back #(
   parameter int IN_WIDTH      = 16,
   parameter int OUT_FRAC_BITS = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [2*IN_WIDTH:0]    w_x,
   input  logic signed [2*IN_WIDTH:0]    w_y,
   input  logic signed [2*IN_WIDTH:0]    w_z,
   input  logic [4*IN_WIDTH+3:0]         s,
   input  upv_pkg::case_code_type        code,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [OUT_FRAC_BITS+1:0] unit_x,
   output logic signed [OUT_FRAC_BITS+1:0] unit_y,
   output logic signed [OUT_FRAC_BITS+1:0] unit_z,
   output upv_pkg::case_code_type        case_code
);
   import upv_pkg::*;

   localparam int MW = 2 * IN_WIDTH + 1;
   localparam int F  = OUT_FRAC_BITS;
   localparam int OW = F + 2;
   localparam int LL = 1 + (2 * F + 1) + (F + 1);

   logic                 en;
   logic signed [MW-1:0] w [3];
   logic [MW-1:0]        m [3];
   logic [F:0]           root [3];
   logic                 v_ff [LL];
   case_code_type        code_ff [LL];
   logic [2:0]           neg_ff [LL];
   logic                 vout_ff;
   logic signed [OW-1:0] u_ff [3];
   case_code_type        cout_ff;

   assign en       = !vout_ff || out_ready;
   assign in_ready = en;
   assign w[0]     = w_x;
   assign w[1]     = w_y;
   assign w[2]     = w_z;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign m[i] = w[i][MW-1] ? MW'(-w[i]) : MW'(w[i]);
      upv_lane #(
         .IN_WIDTH      (IN_WIDTH),
         .OUT_FRAC_BITS (OUT_FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .m     (m[i]),
         .s     (s),
         .root  (root[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LL; k++) begin
            v_ff[k] <= 1'b0;
         end
         vout_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < LL; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         vout_ff <= v_ff[LL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff[0] <= code;
         neg_ff[0]  <= {w[2][MW-1], w[1][MW-1], w[0][MW-1]};
         for (int k = 1; k < LL; k++) begin
            code_ff[k] <= code_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= neg_ff[LL-1][i] ? -OW'({1'b0, root[i]}) : OW'({1'b0, root[i]});
         end
         cout_ff <= code_ff[LL-1];
      end
   end

   assign out_valid = vout_ff;
   assign unit_x    = u_ff[0];
   assign unit_y    = u_ff[1];
   assign unit_z    = u_ff[2];
   assign case_code = cout_ff;

endmodule

FILE: test/unit_perpendicular_vector_tb.sv
module unit_perpendicular_vector_tb;
   import upv_pkg::*;

   localparam int FRAC = 22;
   localparam longint unsigned CROSS_MAX = 64'h7fff_ffff_ffff_ffff;
   localparam longint unsigned LENGTH_MAX = 64'hffff_ffff;
   localparam int CYCLE_LIMIT = 400000;

   // ax lowest, bz highest, same order as req_tdata
   typedef struct packed {
      logic signed [15:0] bz, by, bx, az, ay, ax;
   } pair_type;

   typedef struct packed {
      logic signed [23:0] z, y, x;
   } unit_type;

   typedef struct packed {
      unit_type      u;
      case_code_type code;
   } normal_type;

   typedef struct {
      pair_type   v;
      bit         typed;
      normal_type n;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   longint unsigned cross_limit = 0;
   longint unsigned length_limit = 0;
   normal_type expected_normals[$];
   row_type    directed[$];
   int      failures = 0;
   int      cycles = 0;
   int      words_sent = 0;
   int      case_seen[3] = '{0, 0, 0};
   bit      quiet = 1'b0;
   bit      long_hold = 1'b0;

   unit_perpendicular_vector dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [127:0] square(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
   endfunction

   function automatic unit_type normalize(longint w0, longint w1, longint w2);
      longint       w[3];
      logic [127:0] s, target, cand;
      longint       q;
      longint       r[3];
      unit_type     u;
      w = '{w0, w1, w2};
      s = square(w0) + square(w1) + square(w2);
      for (int i = 0; i < 3; i++) begin
         target = square(w[i]) << (2 * FRAC);
         q = 0;
         for (int b = FRAC; b >= 0; b--) begin
            cand = 128'(q | (64'd1 << b));
            if (cand * cand * s <= target) q = longint'(cand);
         end
         r[i] = (w[i] < 0) ? -q : q;
      end
      u.x = r[0][23:0];
      u.y = r[1][23:0];
      u.z = r[2][23:0];
      return u;
   endfunction

   function automatic normal_type predict_normal(pair_type p);
      longint          a[3], b[3], d[3], w[3], c0, c1, c2;
      longint unsigned la, lb, ld, ad[3];
      int              pi, qi;
      normal_type      n;
      a = '{longint'(p.ax), longint'(p.ay), longint'(p.az)};
      b = '{longint'(p.bx), longint'(p.by), longint'(p.bz)};
      c0 = a[1] * b[2] - a[2] * b[1];
      c1 = a[2] * b[0] - a[0] * b[2];
      c2 = a[0] * b[1] - a[1] * b[0];
      if (square(c0) + square(c1) + square(c2) > 128'(cross_limit)) begin
         n.u = normalize(c0, c1, c2);
         n.code = CASE_CROSS;
         return n;
      end
      la = 64'(square(a[0]) + square(a[1]) + square(a[2]));
      lb = 64'(square(b[0]) + square(b[1]) + square(b[2]));
      if (la < lb) begin
         d = b;
         ld = lb;
      end else begin
         d = a;
         ld = la;
      end
      if (ld <= length_limit) begin
         n.u = '{z: 24'sd0, y: 24'sd0, x: 24'sd4194304};
         n.code = CASE_AXIS;
         return n;
      end
      for (int i = 0; i < 3; i++) ad[i] = (d[i] < 0) ? -d[i] : d[i];
      if (ad[0] < ad[1]) begin
         pi = 1;
         qi = (ad[0] < ad[2]) ? 2 : 0;
      end else begin
         pi = 0;
         qi = (ad[1] < ad[2]) ? 2 : 1;
      end
      w = '{0, 0, 0};
      w[pi] = d[qi];
      w[qi] = -d[pi];
      n.u = normalize(w[0], w[1], w[2]);
      n.code = CASE_PERP;
      return n;
   endfunction

   // response checker
   always @(posedge clock) begin
      normal_type want;
      unit_type   got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_normals.size() == 0) begin
            $error("unexpected response word %h %h", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = expected_normals.pop_front();
            if (got.x !== want.u.x) begin
               $error("unit_x expected %0d got %0d", want.u.x, got.x);
               failures++;
            end
            if (got.y !== want.u.y) begin
               $error("unit_y expected %0d got %0d", want.u.y, got.y);
               failures++;
            end
            if (got.z !== want.u.z) begin
               $error("unit_z expected %0d got %0d", want.u.z, got.z);
               failures++;
            end
            if (rsp_tuser !== want.code) begin
               $error("case_code expected %0d got %0d", want.code, rsp_tuser);
               failures++;
            end
            if (rsp_tuser < 3) case_seen[rsp_tuser]++;
         end
      end
   end

   // response back-pressure
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end else if (quiet || reset) begin
            rsp_tready <= !reset;
         end else if (gap > 0) begin
            gap--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_limit(logic index, longint unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'({index, 3'b000});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_CROSS_LIMIT) cross_limit = value & CROSS_MAX;
      else length_limit = value & LENGTH_MAX;
   endtask

   task automatic send_pair(pair_type p, bit typed, normal_type n);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      expected_normals.push_back(typed ? n : predict_normal(p));
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_normals.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return -16'sd1;
         4: return 16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      p = pair_type'({$urandom, $urandom, $urandom});
      case ($urandom_range(0, 5))
         0: begin
            p.bx = p.ax; p.by = p.ay; p.bz = p.az;
         end
         1: begin
            p.bx = -p.ax; p.by = -p.ay; p.bz = -p.az;
         end
         2: begin
            p.bx = p.ax >>> 1; p.by = p.ay >>> 1; p.bz = p.az >>> 1;
         end
         3: begin
            p.ax = $urandom_range(0, 128) - 64; p.ay = $urandom_range(0, 128) - 64;
            p.az = $urandom_range(0, 128) - 64; p.bx = $urandom_range(0, 128) - 64;
            p.by = $urandom_range(0, 128) - 64; p.bz = $urandom_range(0, 128) - 64;
         end
         4: begin
            p.ax = pick_extreme(); p.ay = pick_extreme(); p.az = pick_extreme();
            p.bx = pick_extreme(); p.by = pick_extreme(); p.bz = pick_extreme();
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic row_type row(int ax, int ay, int az, int bx, int by, int bz,
                                   bit typed = 1'b0, int ux = 0, int uy = 0, int uz = 0,
                                   case_code_type code = CASE_CROSS);
      row_type r;
      r.v = '{bz: 16'(bz), by: 16'(by), bx: 16'(bx), az: 16'(az), ay: 16'(ay), ax: 16'(ax)};
      r.typed = typed;
      r.n.u = '{z: 24'(uz), y: 24'(uy), x: 24'(ux)};
      r.n.code = code;
      return r;
   endfunction

   task automatic random_phase(int count);
      normal_type none;
      none = '0;
      repeat (count) send_pair(random_pair(), 1'b0, none);
      drain();
   endtask

   initial begin
      directed = '{
         row(0, 0, 0, 0, 0, 0, 1, 4194304, 0, 0, CASE_AXIS),
         row(4096, 0, 0, 0, 4096, 0, 1, 0, 0, 4194304, CASE_CROSS),
         row(0, 4096, 0, 4096, 0, 0, 1, 0, 0, -4194304, CASE_CROSS),
         row(4096, 0, 0, 8192, 0, 0, 1, 0, -4194304, 0, CASE_PERP),
         row(-32768, -32768, -32768, 32767, 32767, 32767),
         row(-32768, 32767, -32768, 32767, -32768, 32767),
         row(32767, 0, 0, 0, 0, -32768),
         row(-32768, 0, 0, 0, -32768, 0),
         row(1, 0, 0, 0, 1, 0),
         row(-1, -1, -1, 1, 0, 0),
         row(3, 3, 3, 3, 3, 3),
         row(3, -3, 3, -6, 6, -6),
         row(5, 5, 0, 5, 5, 0),
         row(0, 5, 5, 0, 5, 5),
         row(5, 0, 5, 5, 0, 5),
         row(1, 2, 3, 2, 4, 6),
         row(-7, 2, 1, 7, -2, -1),
         row(0, 0, 0, 100, -300, 200),
         row(12345, -23456, 3456, -111, 22222, -32768),
         row(32767, 32767, 32767, 32767, 32767, 32767),
         row(-32768, -32768, -32768, -32768, -32768, -32768),
         row(1, 1, 0, 0, 0, 0),
         row(0, 0, 0, 0, 0, -1)
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_pair(directed[i].v, directed[i].typed, directed[i].n);
      drain();
      random_phase(70);

      // nearly everything degenerate: perpendicular to the larger vector
      write_limit(REG_CROSS_LIMIT, CROSS_MAX);
      write_limit(REG_LENGTH_LIMIT, 0);
      random_phase(70);

      // both limits at maximum: always the x axis
      write_limit(REG_LENGTH_LIMIT, LENGTH_MAX);
      random_phase(40);

      // mid thresholds under a long response stall
      write_limit(REG_CROSS_LIMIT, {$urandom_range(0, 255), 32'h0} | 64'($urandom));
      write_limit(REG_LENGTH_LIMIT, $urandom_range(0, 65536));
      long_hold = 1'b1;
      random_phase(110);

      // back to zero limits, no idling on either side
      write_limit(REG_CROSS_LIMIT, 0);
      write_limit(REG_LENGTH_LIMIT, 0);
      quiet = 1'b1;
      random_phase(110);

      repeat (100) @(posedge clock);
      $display("sent %0d vector pairs over five limit settings", words_sent);
      $display("results by case: cross %0d, perpendicular %0d, x axis %0d",
               case_seen[0], case_seen[1], case_seen[2]);
      if (failures == 0 && expected_normals.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/upv_pkg.sv
hdl/upv_front.sv
hdl/upv_fifo.sv
hdl/upv_lane.sv
hdl/upv_back.sv
hdl/unit_perpendicular_vector.sv
test/unit_perpendicular_vector_tb.sv
